// ===== hw/rtl/qbap_pkg.sv =====
`timescale 1ns / 1ps

package qbap_pkg;

   localparam int unsigned COORD_W = 32;
   localparam int unsigned OPND_W  = 34;
   localparam int unsigned PROD_W  = 2 * OPND_W;
   localparam int unsigned T_W     = 17;
   localparam int unsigned SEG_W   = 6;
   localparam int unsigned WGT_W   = 33;
   localparam int unsigned FACT_W  = 18;

   localparam logic [SEG_W-1:0] MAX_SEGMENTS  = 6'd63;
   localparam logic [SEG_W-1:0] SEG_RESET     = 6'd20;
   localparam logic [T_W-1:0]   ONE_Q16       = 17'd65536;
   localparam logic [FACT_W-1:0] LIFT_Q16     = 18'd11141;
   localparam logic [OPND_W-1:0] ONE_Q32      = 34'h1_0000_0000;

   localparam int unsigned SH_HALF   = 1;
   localparam int unsigned SH_LIFT   = 17;
   localparam int unsigned SH_POINT  = 32;

   localparam logic signed [PROD_W-1:0] SAT_MAX = 68'sd2147483647;
   localparam logic signed [PROD_W-1:0] SAT_MIN = -68'sd2147483648;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [OPND_W-1:0]  opnd_type;
   typedef logic signed [PROD_W-1:0]  prod_type;

   typedef struct packed {
      logic                done;
      logic [T_W-1:0]      quot;
      logic [SEG_W-1:0]    rem;
   } div_res_type;

   // round to nearest, ties away from zero, then saturate to 32 bits
   function automatic coord_type rnd_sat(input prod_type v, input int unsigned sh);
      prod_type half;
      prod_type biased;
      prod_type q;
      half   = prod_type'(1) <<< (sh - 1);
      biased = v + half - prod_type'(v[PROD_W-1]);
      q      = biased >>> sh;
      if (q > SAT_MAX) begin
         return coord_type'(SAT_MAX);
      end else if (q < SAT_MIN) begin
         return coord_type'(SAT_MIN);
      end else begin
         return q[COORD_W-1:0];
      end
   endfunction

endpackage

// ===== hw/rtl/quadratic_bezier_arc_points.sv =====
`timescale 1ns / 1ps
// Each point runs on the single shared 34x34 multiplier, in order:
// two weight products, nine coordinate products, drain, output load.
// A new request is taken only once the last point of an item is loaded.
// Reset: synchronous; segment count returns to 20, sequencer to idle.

module quadratic_bezier_arc_points (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [5:0]           csr_wr_data,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic signed [31:0]   req_start_x,
   input  logic signed [31:0]   req_start_y,
   input  logic signed [31:0]   req_start_z,
   input  logic signed [31:0]   req_end_x,
   input  logic signed [31:0]   req_end_y,
   input  logic signed [31:0]   req_end_z,
   input  logic [3:0]           req_curvature,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [31:0]   rsp_point_x,
   output logic signed [31:0]   rsp_point_y,
   output logic signed [31:0]   rsp_point_z,
   output logic [5:0]           rsp_point_index,
   output logic                 rsp_last_point
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_CZ, ST_CZ_RND, ST_DIV, ST_T, ST_WT, ST_WU, ST_PROD, ST_DRAIN, ST_OUT
   } state_type;

   state_type state_ff;

   logic [5:0]                      num_seg_ff;
   logic [5:0]                      n_eff;
   logic [5:0]                      n_ff;
   logic [5:0]                      i_ff;

   qbap_pkg::coord_type             start_ff [3];
   qbap_pkg::coord_type             ctrl_ff  [3];
   qbap_pkg::coord_type             end_ff   [3];
   qbap_pkg::coord_type             pt_ff    [3];
   logic signed [32:0]              sumz_ff;
   logic [qbap_pkg::FACT_W-1:0]     factor_ff;

   logic [qbap_pkg::T_W-1:0]        t_ff;
   logic [qbap_pkg::T_W-1:0]        u_val;
   logic [qbap_pkg::T_W-1:0]        q_ff;
   logic [5:0]                      rr_ff;
   logic [5:0]                      tr_ff;
   logic [6:0]                      rsum;
   logic                            carry;

   logic [qbap_pkg::WGT_W-1:0]      w0_ff;
   logic [qbap_pkg::WGT_W-1:0]      w1_ff;
   logic [qbap_pkg::WGT_W-1:0]      w2_ff;

   logic [1:0]                      pj_ff;
   logic [1:0]                      pk_ff;
   logic                            acc_en_ff;
   logic                            acc_first_ff;
   logic                            acc_last_ff;
   logic [1:0]                      acc_k_ff;
   logic                            rnd_en_ff;
   logic [1:0]                      rnd_k_ff;
   qbap_pkg::prod_type              acc_ff;

   qbap_pkg::opnd_type              op_a;
   qbap_pkg::opnd_type              op_b;
   qbap_pkg::prod_type              prod;
   qbap_pkg::div_res_type           div_res;

   logic                            rsp_valid_ff;
   qbap_pkg::coord_type             rsp_x_ff;
   qbap_pkg::coord_type             rsp_y_ff;
   qbap_pkg::coord_type             rsp_z_ff;
   logic [5:0]                      rsp_idx_ff;
   logic                            rsp_last_ff;

   logic                            in_xfer;
   logic                            out_free;
   logic                            last;

   qbap_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   qbap_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (in_xfer),
      .divisor (n_eff),
      .res     (div_res)
   );

   always_comb begin
      req_stall = state_ff != ST_IDLE;
      in_xfer   = req_valid && !req_stall;
      out_free  = !rsp_valid_ff || !rsp_stall;
      last      = i_ff == n_ff;
      u_val     = qbap_pkg::ONE_Q16 - t_ff;
      rsum      = {1'b0, tr_ff} + {1'b0, rr_ff};
      carry     = rsum >= {1'b0, n_ff};
      if (num_seg_ff == 6'd0) begin
         n_eff = 6'd1;
      end else if (num_seg_ff > qbap_pkg::MAX_SEGMENTS) begin
         n_eff = qbap_pkg::MAX_SEGMENTS;
      end else begin
         n_eff = num_seg_ff;
      end
   end

   always_comb begin
      op_a = '0;
      op_b = '0;
      case (state_ff)
         ST_CZ: begin
            op_a = qbap_pkg::OPND_W'(sumz_ff);
            op_b = {16'd0, factor_ff};
         end
         ST_T: begin
            op_a = {17'd0, t_ff};
            op_b = {17'd0, t_ff};
         end
         ST_WT: begin
            op_a = {17'd0, u_val};
            op_b = {17'd0, u_val};
         end
         ST_PROD: begin
            case (pj_ff)
               2'd0: begin
                  op_a = qbap_pkg::OPND_W'(start_ff[pk_ff]);
                  op_b = {1'b0, w0_ff};
               end
               2'd1: begin
                  op_a = qbap_pkg::OPND_W'(ctrl_ff[pk_ff]);
                  op_b = {1'b0, w1_ff};
               end
               default: begin
                  op_a = qbap_pkg::OPND_W'(end_ff[pk_ff]);
                  op_b = {1'b0, w2_ff};
               end
            endcase
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         num_seg_ff   <= qbap_pkg::SEG_RESET;
         rsp_valid_ff <= 1'b0;
         acc_en_ff    <= 1'b0;
         rnd_en_ff    <= 1'b0;
         i_ff         <= '0;
         n_ff         <= 6'd1;
         t_ff         <= '0;
         tr_ff        <= '0;
      end else begin
         if (csr_wr_en) begin
            num_seg_ff <= csr_wr_data;
         end

         acc_en_ff    <= state_ff == ST_PROD;
         acc_first_ff <= pj_ff == 2'd0;
         acc_last_ff  <= pj_ff == 2'd2;
         acc_k_ff     <= pk_ff;
         if (acc_en_ff) begin
            acc_ff <= acc_first_ff ? prod : acc_ff + prod;
         end
         rnd_en_ff <= acc_en_ff && acc_last_ff;
         rnd_k_ff  <= acc_k_ff;
         if (rnd_en_ff) begin
            pt_ff[rnd_k_ff] <= qbap_pkg::rnd_sat(acc_ff, qbap_pkg::SH_POINT);
         end

         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (in_xfer) begin
                  start_ff[0] <= req_start_x;
                  start_ff[1] <= req_start_y;
                  start_ff[2] <= req_start_z;
                  end_ff[0]   <= req_end_x;
                  end_ff[1]   <= req_end_y;
                  end_ff[2]   <= req_end_z;
                  ctrl_ff[0]  <= qbap_pkg::rnd_sat(qbap_pkg::PROD_W'(req_start_x)
                                    + qbap_pkg::PROD_W'(req_end_x), qbap_pkg::SH_HALF);
                  ctrl_ff[1]  <= qbap_pkg::rnd_sat(qbap_pkg::PROD_W'(req_start_y)
                                    + qbap_pkg::PROD_W'(req_end_y), qbap_pkg::SH_HALF);
                  sumz_ff     <= 33'(req_start_z) + 33'(req_end_z);
                  factor_ff   <= qbap_pkg::FACT_W'(qbap_pkg::ONE_Q16)
                                 + qbap_pkg::FACT_W'(req_curvature) * qbap_pkg::LIFT_Q16;
                  n_ff        <= n_eff;
                  state_ff    <= ST_CZ;
               end
            end
            ST_CZ: begin
               state_ff <= ST_CZ_RND;
            end
            ST_CZ_RND: begin
               ctrl_ff[2] <= qbap_pkg::rnd_sat(prod, qbap_pkg::SH_LIFT);
               state_ff   <= ST_DIV;
            end
            ST_DIV: begin
               if (div_res.done) begin
                  q_ff     <= div_res.quot;
                  rr_ff    <= div_res.rem;
                  t_ff     <= '0;
                  tr_ff    <= n_ff >> 1;
                  i_ff     <= '0;
                  state_ff <= ST_T;
               end
            end
            ST_T: begin
               state_ff <= ST_WT;
            end
            ST_WT: begin
               w2_ff    <= prod[qbap_pkg::WGT_W-1:0];
               state_ff <= ST_WU;
            end
            ST_WU: begin
               w0_ff    <= prod[qbap_pkg::WGT_W-1:0];
               w1_ff    <= qbap_pkg::WGT_W'(qbap_pkg::ONE_Q32
                                 - {1'b0, prod[qbap_pkg::WGT_W-1:0]} - {1'b0, w2_ff});
               pj_ff    <= '0;
               pk_ff    <= '0;
               state_ff <= ST_PROD;
            end
            ST_PROD: begin
               if (pj_ff == 2'd2) begin
                  pj_ff <= '0;
                  pk_ff <= pk_ff + 2'd1;
                  if (pk_ff == 2'd2) begin
                     state_ff <= ST_DRAIN;
                  end
               end else begin
                  pj_ff <= pj_ff + 2'd1;
               end
            end
            ST_DRAIN: begin
               if (rnd_en_ff && rnd_k_ff == 2'd2) begin
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (out_free) begin
                  rsp_x_ff     <= pt_ff[0];
                  rsp_y_ff     <= pt_ff[1];
                  rsp_z_ff     <= pt_ff[2];
                  rsp_idx_ff   <= i_ff;
                  rsp_last_ff  <= last;
                  if (last) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     i_ff     <= i_ff + 6'd1;
                     tr_ff    <= carry ? 6'(rsum - {1'b0, n_ff}) : rsum[5:0];
                     t_ff     <= t_ff + q_ff + qbap_pkg::T_W'(carry);
                     state_ff <= ST_T;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_point_x     = rsp_x_ff;
   assign rsp_point_y     = rsp_y_ff;
   assign rsp_point_z     = rsp_z_ff;
   assign rsp_point_index = rsp_idx_ff;
   assign rsp_last_point  = rsp_last_ff;

   a_t_first_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_T && i_ff == 6'd0) |-> t_ff == '0)
      else $error("t not zero on first point");

   a_t_last_one: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_T && i_ff == n_ff) |-> t_ff == qbap_pkg::ONE_Q16)
      else $error("t not one on last point");

   a_rem_below_n: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_T) |-> tr_ff < n_ff)
      else $error("t remainder out of range");

   a_out_from_seq: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_OUT))
      else $error("result loaded outside output step");

endmodule

// ===== hw/rtl/qbap_mul.sv =====
`timescale 1ns / 1ps

module qbap_mul (
   input  logic               clock,
   input  qbap_pkg::opnd_type op_a,
   input  qbap_pkg::opnd_type op_b,
   output qbap_pkg::prod_type prod
);

   qbap_pkg::prod_type prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   assign prod = prod_ff;

endmodule

// ===== hw/rtl/qbap_div.sv =====
`timescale 1ns / 1ps

module qbap_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [qbap_pkg::SEG_W-1:0]      divisor,
   output qbap_pkg::div_res_type           res
);

   // 65536 / divisor, one quotient bit per cycle
   logic                          busy_ff;
   logic                          done_ff;
   logic [4:0]                    cnt_ff;
   logic [qbap_pkg::T_W-1:0]      quot_ff;
   logic [qbap_pkg::SEG_W-1:0]    rem_ff;
   logic [qbap_pkg::SEG_W-1:0]    dvs_ff;

   logic [qbap_pkg::SEG_W:0]      trial;
   logic                          ge;

   always_comb begin
      trial = {rem_ff, (cnt_ff == 5'd0)};
      ge    = trial >= {1'b0, dvs_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         if (start) begin
            busy_ff <= 1'b1;
            done_ff <= 1'b0;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            quot_ff <= '0;
            dvs_ff  <= divisor;
         end else if (busy_ff) begin
            rem_ff  <= ge ? qbap_pkg::SEG_W'(trial - {1'b0, dvs_ff})
                          : trial[qbap_pkg::SEG_W-1:0];
            quot_ff <= {quot_ff[qbap_pkg::T_W-2:0], ge};
            cnt_ff  <= cnt_ff + 5'd1;
            if (cnt_ff == 5'(qbap_pkg::T_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign res.done = done_ff;
   assign res.quot = quot_ff;
   assign res.rem  = rem_ff;

endmodule

// ===== verif/qbap_arc_checker.sv =====
`timescale 1ns / 1ps

module qbap_arc_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [5:0]           csr_wr_data,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic signed [31:0]   req_start_x,
   input  logic signed [31:0]   req_start_y,
   input  logic signed [31:0]   req_start_z,
   input  logic signed [31:0]   req_end_x,
   input  logic signed [31:0]   req_end_y,
   input  logic signed [31:0]   req_end_z,
   input  logic [3:0]           req_curvature,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic signed [31:0]   rsp_point_x,
   input  logic signed [31:0]   rsp_point_y,
   input  logic signed [31:0]   rsp_point_z,
   input  logic [5:0]           rsp_point_index,
   input  logic                 rsp_last_point,
   output int                   fail_count,
   output int                   points_pending
);

   localparam longint COORD_HI = 64'sd2147483647;
   localparam longint COORD_LO = -64'sd2147483648;

   typedef struct {
      qbap_pkg::coord_type               x;
      qbap_pkg::coord_type               y;
      qbap_pkg::coord_type               z;
      logic [qbap_pkg::SEG_W-1:0]        idx;
      logic                              last;
   } arc_point_type;

   arc_point_type                 points_due[$];
   logic [qbap_pkg::SEG_W-1:0]    seg_count  = qbap_pkg::SEG_RESET;
   int                            mismatches = 0;
   int                            due_count  = 0;

   assign fail_count     = mismatches;
   assign points_pending = due_count;

   function automatic qbap_pkg::coord_type clamp32(input longint v);
      if (v > COORD_HI) begin
         return qbap_pkg::coord_type'(COORD_HI);
      end else if (v < COORD_LO) begin
         return qbap_pkg::coord_type'(COORD_LO);
      end
      return qbap_pkg::coord_type'(v);
   endfunction

   // nearest, ties away from zero
   function automatic qbap_pkg::coord_type round_shift(input logic neg,
                                                       input logic [63:0] mag,
                                                       input int unsigned sh);
      longint q;
      q = longint'((mag + (64'd1 << (sh - 1))) >> sh);
      return clamp32(neg ? -q : q);
   endfunction

   function automatic qbap_pkg::coord_type round_signed(input longint v,
                                                        input int unsigned sh);
      logic [63:0] mag;
      mag = (v < 0) ? -v : v;
      return round_shift(v < 0, mag, sh);
   endfunction

   function automatic qbap_pkg::coord_type curve_axis(input qbap_pkg::coord_type s,
                                                      input qbap_pkg::coord_type c,
                                                      input qbap_pkg::coord_type e,
                                                      input logic [63:0] t);
      logic [63:0] u;
      logic [63:0] sv;
      logic [63:0] cv;
      logic [63:0] ev;
      logic [63:0] acc;
      logic [63:0] mag;
      longint      tmp;
      tmp = s;
      sv  = tmp;
      tmp = c;
      cv  = tmp;
      tmp = e;
      ev  = tmp;
      u   = 64'd65536 - t;
      acc = sv * (u * u) + cv * (64'd2 * u * t) + ev * (t * t);
      mag = acc[63] ? (~acc + 64'd1) : acc;
      return round_shift(acc[63], mag, qbap_pkg::SH_POINT);
   endfunction

   task automatic predict_arc();
      qbap_pkg::coord_type  s[3];
      qbap_pkg::coord_type  e[3];
      qbap_pkg::coord_type  c[3];
      longint               sum;
      longint               lift;
      int unsigned          n;
      logic [63:0]          t;
      arc_point_type        pt;
      s[0] = req_start_x;
      s[1] = req_start_y;
      s[2] = req_start_z;
      e[0] = req_end_x;
      e[1] = req_end_y;
      e[2] = req_end_z;
      n = 32'(seg_count);
      if (n < 1) n = 1;
      if (n > 32'(qbap_pkg::MAX_SEGMENTS)) n = 32'(qbap_pkg::MAX_SEGMENTS);
      for (int k = 0; k < 2; k++) begin
         sum  = longint'(s[k]) + longint'(e[k]);
         c[k] = round_signed(sum, qbap_pkg::SH_HALF);
      end
      sum  = longint'(s[2]) + longint'(e[2]);
      lift = 64'sd65536 + longint'(req_curvature) * longint'(qbap_pkg::LIFT_Q16);
      c[2] = round_signed(sum * lift, qbap_pkg::SH_LIFT);
      for (int unsigned i = 0; i <= n; i++) begin
         t = (64'(i) * 64'd65536 + 64'(n / 2)) / 64'(n);
         pt.x    = curve_axis(s[0], c[0], e[0], t);
         pt.y    = curve_axis(s[1], c[1], e[1], t);
         pt.z    = curve_axis(s[2], c[2], e[2], t);
         pt.idx  = i[qbap_pkg::SEG_W-1:0];
         pt.last = (i == n);
         points_due.push_back(pt);
      end
   endtask

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      arc_point_type want;
      if (reset) begin
         points_due.delete();
         seg_count = qbap_pkg::SEG_RESET;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (points_due.size() == 0) begin
               mismatches++;
               $display("%0t: point transfer with none expected, got x=%0d y=%0d z=%0d i=%0d",
                        $time, rsp_point_x, rsp_point_y, rsp_point_z, rsp_point_index);
            end else begin
               want = points_due.pop_front();
               check_field("point_x", want.x, rsp_point_x);
               check_field("point_y", want.y, rsp_point_y);
               check_field("point_z", want.z, rsp_point_z);
               check_field("point_index", want.idx, rsp_point_index);
               check_field("last_point", want.last, rsp_last_point);
            end
         end
         if (req_valid && !req_stall) begin
            predict_arc();
         end
         if (csr_wr_en) begin
            seg_count = csr_wr_data;
         end
      end
      due_count = points_due.size();
   end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RUN_LIMIT      = 400000;
   localparam qbap_pkg::coord_type C_MAX = 32'sh7fffffff;
   localparam qbap_pkg::coord_type C_MIN = 32'sh80000000;

   typedef struct {
      qbap_pkg::coord_type   sx;
      qbap_pkg::coord_type   sy;
      qbap_pkg::coord_type   sz;
      qbap_pkg::coord_type   ex;
      qbap_pkg::coord_type   ey;
      qbap_pkg::coord_type   ez;
      logic [3:0]            curv;
   } arc_req_type;

   logic                clock           = 1'b0;
   logic                reset           = 1'b1;
   logic                csr_wr_en       = 1'b0;
   logic [5:0]          csr_wr_data     = '0;
   logic                req_valid       = 1'b0;
   logic                req_stall;
   logic signed [31:0]  req_start_x     = '0;
   logic signed [31:0]  req_start_y     = '0;
   logic signed [31:0]  req_start_z     = '0;
   logic signed [31:0]  req_end_x       = '0;
   logic signed [31:0]  req_end_y       = '0;
   logic signed [31:0]  req_end_z       = '0;
   logic [3:0]          req_curvature   = '0;
   logic                rsp_valid;
   logic                rsp_stall       = 1'b0;
   logic signed [31:0]  rsp_point_x;
   logic signed [31:0]  rsp_point_y;
   logic signed [31:0]  rsp_point_z;
   logic [5:0]          rsp_point_index;
   logic                rsp_last_point;
   int                  fail_count;
   int                  points_pending;

   bit                  quiet        = 1'b0;
   bit                  hold_request = 1'b0;
   bit                  hold_done    = 1'b0;
   int                  idle_cycles  = 0;
   int                  run_cycles   = 0;

   quadratic_bezier_arc_points dut (.*);

   qbap_arc_checker chk (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver side
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_stall <= !quiet && ($urandom_range(0, 99) < 26);
      end
   end

   always @(posedge clock) begin
      run_cycles <= run_cycles + 1;
      if (run_cycles >= RUN_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   function automatic arc_req_type make_curve(input qbap_pkg::coord_type sx,
                                              input qbap_pkg::coord_type sy,
                                              input qbap_pkg::coord_type sz,
                                              input qbap_pkg::coord_type ex,
                                              input qbap_pkg::coord_type ey,
                                              input qbap_pkg::coord_type ez,
                                              input logic [3:0] curv);
      arc_req_type r;
      r.sx   = sx;
      r.sy   = sy;
      r.sz   = sz;
      r.ex   = ex;
      r.ey   = ey;
      r.ez   = ez;
      r.curv = curv;
      return r;
   endfunction

   function automatic qbap_pkg::coord_type random_coord();
      case ($urandom_range(0, 9))
         0: return C_MAX;
         1: return C_MIN;
         2, 3: return qbap_pkg::coord_type'(int'($urandom_range(0, 8192)) - 4096);
         default: return qbap_pkg::coord_type'($urandom);
      endcase
   endfunction

   function automatic arc_req_type random_curve();
      return make_curve(random_coord(), random_coord(), random_coord(), random_coord(),
                        random_coord(), random_coord(), 4'($urandom_range(0, 15)));
   endfunction

   // entered and left at a falling edge
   task automatic send_curve(input arc_req_type r);
      while (!quiet && $urandom_range(0, 99) < 26) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_start_x   <= r.sx;
      req_start_y   <= r.sy;
      req_start_z   <= r.sz;
      req_end_x     <= r.ex;
      req_end_y     <= r.ey;
      req_end_z     <= r.ez;
      req_curvature <= r.curv;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (points_pending != 0) @(negedge clock);
   endtask

   task automatic set_segments(input logic [5:0] count);
      wait_drain();
      repeat (8) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= count;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      logic [5:0] n_set;
      int         items;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset segment count
      send_curve(make_curve(0, 0, 0, 0, 0, 0, 0));
      send_curve(make_curve(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 15));
      send_curve(make_curve(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, 15));
      send_curve(make_curve(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, 7));
      send_curve(make_curve(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 8));
      // halves round away from zero
      send_curve(make_curve(3, -3, -3, 0, 0, 0, 0));
      send_curve(make_curve(256, -512, 1024, -256, 512, 2048, 1));
      send_curve(make_curve(-1, -1, -1, 1, 1, 1, 15));
      send_curve(random_curve());

      // zero count behaves as one segment
      set_segments(6'd0);
      send_curve(make_curve(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MAX, 15));
      send_curve(make_curve(-7, 7, -7, 8, -8, 9, 3));
      send_curve(random_curve());

      set_segments(qbap_pkg::MAX_SEGMENTS);
      send_curve(make_curve(C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MIN, 15));
      send_curve(make_curve(1000, -1000, 5000, -3000, 3000, -5000, 9));
      send_curve(random_curve());

      set_segments(6'd1);
      send_curve(make_curve(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 0));
      send_curve(random_curve());

      for (int phase = 0; phase < 14; phase++) begin
         if (phase == 5) begin
            n_set = qbap_pkg::MAX_SEGMENTS;
            items = 3;
         end else if (phase == 11) begin
            n_set = 6'($urandom_range(10, 40));
            items = 5;
         end else begin
            n_set = 6'($urandom_range(0, 9));
            items = 9;
         end
         set_segments(n_set);
         if (phase == 2) hold_request = 1'b1;
         quiet = (phase == 7);
         for (int k = 0; k < items; k++) begin
            send_curve(random_curve());
            if (phase == 9 && k == 4) wait_drain();
         end
      end

      wait_drain();
      repeat (40) @(negedge clock);
      if (fail_count == 0 && points_pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
